>>> design/tcw_pkg.sv
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS);
  localparam int AW = $clog2(CELLS);

  localparam int ROW_FW = 5;
  localparam int COL_FW = 7;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;
  localparam logic [CHAR_W-1:0] COLOR_RESET  = 8'd7;

  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FILL
  } ctl_state_t;

  typedef struct packed {
    logic put;
    logic read_issue;
    logic read_load;
    logic clear_wr;
    logic fill_wr;
    logic fill_start;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic read_item;
    logic will_scroll;
    logic sweep_last;
  } dp_status_t;

endpackage

>>> design/tcw_in_if.sv
interface tcw_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [tcw_pkg::CHAR_W-1:0]  char_code;
  logic [tcw_pkg::ROW_FW-1:0]  read_row;
  logic [tcw_pkg::COL_FW-1:0]  read_col;

  modport source (output valid, action, char_code, read_row, read_col, input ready);
  modport sink (input valid, action, char_code, read_row, read_col, output ready);
endinterface

>>> design/tcw_out_if.sv
interface tcw_out_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::ROW_FW-1:0]  cursor_row;
  logic [tcw_pkg::COL_FW-1:0]  cursor_col;
  logic [tcw_pkg::CELL_W-1:0]  cell_data;
  logic                        scrolled;

  modport source (output valid, cursor_row, cursor_col, cell_data, scrolled, input ready);
  modport sink (input valid, cursor_row, cursor_col, cell_data, scrolled, output ready);
endinterface

>>> design/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/tcw_ctrl.sv
module tcw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcw_pkg::dp_status_t status,
  output tcw_pkg::ctl_cmd_t   cmd
);
  import tcw_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       take;

  assign take = (state_r == ST_IDLE) && status.out_free && in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (status.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take && status.read_item) begin
          state_nxt = ST_READ;
        end else if (take && status.will_scroll) begin
          state_nxt = ST_FILL;
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      ST_FILL: begin
        if (status.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
      end
      ST_IDLE: begin
        in_ready        = status.out_free;
        cmd.put         = take && !status.read_item;
        cmd.read_issue  = take && status.read_item;
        cmd.fill_start  = take && !status.read_item && status.will_scroll;
      end
      ST_READ: begin
        cmd.read_load = 1'b1;
      end
      ST_FILL: begin
        cmd.fill_wr = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> design/tcw_datapath.sv
module tcw_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tcw_pkg::ctl_cmd_t            cmd,
  output tcw_pkg::dp_status_t          status,
  input  logic                         item_action,
  input  logic [tcw_pkg::CHAR_W-1:0]   item_char,
  input  logic [tcw_pkg::ROW_FW-1:0]   item_row,
  input  logic [tcw_pkg::COL_FW-1:0]   item_col,
  input  logic                         cfg_wr_en,
  input  logic [tcw_pkg::CHAR_W-1:0]   cfg_wr_data,
  tcw_out_if.source                    out_ch
);
  import tcw_pkg::*;

  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r, input logic [RW-1:0] t);
    logic [RW:0] s;
    s = {1'b0, r} + {1'b0, t};
    if (s >= (RW+1)'(ROWS)) begin
      s = s - (RW+1)'(ROWS);
    end
    return RW'(s);
  endfunction

  logic [RW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     top_r, top_nxt;
  logic [CHAR_W-1:0] color_r, color_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     last_r, last_nxt;
  logic              rd_ok_r, rd_ok_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [ROW_FW-1:0] out_row_r, out_row_nxt;
  logic [COL_FW-1:0] out_col_r, out_col_nxt;
  logic [CELL_W-1:0] out_cell_r, out_cell_nxt;
  logic              out_scr_r, out_scr_nxt;

  logic [RW-1:0]     put_row;
  logic [CW-1:0]     put_col;
  logic [CW-1:0]     put_wcol;
  logic [CHAR_W-1:0] put_char;
  logic              put_we;
  logic              adv;
  logic              scroll;
  logic [CW:0]       col_inc;
  logic [AW-1:0]     put_addr;
  logic [AW-1:0]     fill_base;

  logic              rd_in_range;
  logic [RW-1:0]     rd_row;
  logic [AW-1:0]     rd_addr;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [CELL_W-1:0] ram_rdata;

  assign col_inc = {1'b0, col_r} + (CW+1)'(1);

  // cursor update for a put
  always_comb begin
    put_col  = col_r;
    put_wcol = col_r;
    put_char = item_char;
    put_we   = 1'b0;
    adv      = 1'b0;
    if (item_char == CH_NEWLINE) begin
      put_col = '0;
      adv     = 1'b1;
    end else if (item_char == CH_BACKSPACE) begin
      if (col_r != '0) begin
        put_col  = col_r - CW'(1);
        put_wcol = col_r - CW'(1);
        put_char = CH_BLANK;
        put_we   = 1'b1;
      end
    end else begin
      put_we = 1'b1;
      if (col_inc == (CW+1)'(COLUMNS)) begin
        put_col = '0;
        adv     = 1'b1;
      end else begin
        put_col = CW'(col_inc);
      end
    end
    scroll  = adv && (row_r == LAST_ROW);
    put_row = row_r;
    if (adv) begin
      put_row = scroll ? LAST_ROW : row_r + RW'(1);
    end
  end

  assign put_addr  = AW'(phys_row(row_r, top_r)) * AW'(COLUMNS) + AW'(put_wcol);
  assign fill_base = AW'(top_r) * AW'(COLUMNS);

  assign rd_in_range = (32'(item_row) < ROWS) && (32'(item_col) < COLUMNS);
  assign rd_row      = rd_in_range ? RW'(item_row) : '0;
  assign rd_addr     = AW'(phys_row(rd_row, top_r)) * AW'(COLUMNS)
                     + (rd_in_range ? AW'(item_col) : '0);

  assign ram_we    = cmd.clear_wr || cmd.fill_wr || (cmd.put && put_we);
  assign ram_waddr = (cmd.clear_wr || cmd.fill_wr) ? cnt_r : put_addr;
  always_comb begin
    if (cmd.clear_wr) begin
      ram_wdata = '0;
    end else if (cmd.fill_wr) begin
      ram_wdata = {color_r, CH_BLANK};
    end else begin
      ram_wdata = {color_r, put_char};
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (cmd.read_issue),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    row_nxt   = row_r;
    col_nxt   = col_r;
    top_nxt   = top_r;
    color_nxt = cfg_wr_en ? cfg_wr_data : color_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    rd_ok_nxt = rd_ok_r;

    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_cell_nxt  = out_cell_r;
    out_scr_nxt   = out_scr_r;

    if (cmd.clear_wr || cmd.fill_wr) begin
      cnt_nxt = cnt_r + AW'(1);
    end

    if (cmd.put) begin
      row_nxt       = put_row;
      col_nxt       = put_col;
      out_valid_nxt = 1'b1;
      out_row_nxt   = ROW_FW'(put_row);
      out_col_nxt   = COL_FW'(put_col);
      out_cell_nxt  = '0;
      out_scr_nxt   = scroll;
    end

    // new bottom row reuses the old top row
    if (cmd.fill_start) begin
      top_nxt  = (top_r == LAST_ROW) ? '0 : top_r + RW'(1);
      cnt_nxt  = fill_base;
      last_nxt = fill_base + AW'(COLUMNS - 1);
    end

    if (cmd.read_issue) begin
      rd_ok_nxt = rd_in_range;
    end

    if (cmd.read_load) begin
      out_valid_nxt = 1'b1;
      out_row_nxt   = ROW_FW'(row_r);
      out_col_nxt   = COL_FW'(col_r);
      out_cell_nxt  = rd_ok_r ? ram_rdata : '0;
      out_scr_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      top_r       <= '0;
      color_r     <= COLOR_RESET;
      cnt_r       <= '0;
      last_r      <= LAST_CELL;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      top_r       <= top_nxt;
      color_r     <= color_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ok_r    <= rd_ok_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_cell_r <= out_cell_nxt;
    out_scr_r  <= out_scr_nxt;
  end

  assign status.out_free    = !out_valid_r || out_ch.ready;
  assign status.read_item   = (item_action == ACT_READ);
  assign status.will_scroll = scroll;
  assign status.sweep_last  = (cnt_r == last_r);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cursor_row = out_row_r;
  assign out_ch.cursor_col = out_col_r;
  assign out_ch.cell_data  = out_cell_r;
  assign out_ch.scrolled   = out_scr_r;

endmodule

>>> design/text_console_writer.sv
// text_console_writer: character-cell console, 25 rows of 80 cells, with a cursor
// in_ch: one transfer per item; action 0 puts char_code at the cursor
//   (newline, backspace or printable), action 1 reads the cell at read_row/read_col
// out_ch: one transfer per item with the cursor after the item, the cell read
//   (zero for a put or an out-of-range read) and a scroll flag
// cfg_wr_en/cfg_wr_data: sets the attribute byte of cells that puts and scrolls write
// puts that do not scroll can follow back to back while the receiver takes the results
// a read passes through the READ state, as the cell memory has a registered read port
// a put that scrolls moves a top-row pointer and then blanks the new bottom row
//   one cell per cycle through the single write port
// the result sits in an output register; the next item is taken while it waits
//   as long as the receiver takes it in the same cycle, otherwise in_ch.ready
//   stays low until the transfer completes
// after reset the memory is cleared to zero, one cell per cycle;
//   in_ch.ready is low during that pass, configuration writes are taken
module text_console_writer (
  input  logic                       clk,
  input  logic                       rst_n,
  tcw_in_if.sink                     in_ch,
  tcw_out_if.source                  out_ch,
  input  logic                       cfg_wr_en,
  input  logic [tcw_pkg::CHAR_W-1:0] cfg_wr_data
);
  import tcw_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tcw_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .item_action (in_ch.action),
    .item_char   (in_ch.char_code),
    .item_row    (in_ch.read_row),
    .item_col    (in_ch.read_col),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ch      (out_ch)
  );

endmodule

>>> sim/tcw_screen_checker.sv
`timescale 1ns / 100ps

module tcw_screen_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  tcw_in_if                          in_mon,
  tcw_out_if                         out_mon,
  input  logic                       cfg_wr_en,
  input  logic [tcw_pkg::CHAR_W-1:0] cfg_wr_data,
  output int                         mismatches,
  output int                         results_outstanding,
  output int                         scrolls_seen
);
  import tcw_pkg::*;

  typedef struct packed {
    logic [ROW_FW-1:0] cur_row;
    logic [COL_FW-1:0] cur_col;
    logic [CELL_W-1:0] cell_word;
    logic              scrolled;
  } console_result_t;

  logic [CELL_W-1:0] screen [CELLS];
  int                cursor_row;
  int                cursor_col;
  logic [CHAR_W-1:0] attribute;
  console_result_t   cursor_cell_q [$];

  task automatic report_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 100) begin
      $display("%0t mismatch %s: expected 'h%0h, got 'h%0h", $time, what, want, got);
    end
  endtask

  task automatic console_step(input logic act, input logic [CHAR_W-1:0] ch,
                              input logic [ROW_FW-1:0] rd_row,
                              input logic [COL_FW-1:0] rd_col,
                              output console_result_t res);
    int i;
    res = '0;
    if (act == ACT_READ) begin
      if (rd_row < ROWS && rd_col < COLUMNS) begin
        res.cell_word = screen[rd_row * COLUMNS + rd_col];
      end
    end else begin
      if (ch == CH_NEWLINE) begin
        cursor_col = 0;
        cursor_row++;
      end else if (ch == CH_BACKSPACE) begin
        if (cursor_col > 0) begin
          cursor_col--;
          screen[cursor_row * COLUMNS + cursor_col] = {attribute, CH_BLANK};
        end
      end else begin
        screen[cursor_row * COLUMNS + cursor_col] = {attribute, ch};
        cursor_col++;
      end
      if (cursor_col >= COLUMNS) begin
        cursor_col = 0;
        cursor_row++;
      end
      if (cursor_row >= ROWS) begin
        for (i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
          screen[i] = screen[i + COLUMNS];
        end
        for (i = (ROWS - 1) * COLUMNS; i < CELLS; i++) begin
          screen[i] = {attribute, CH_BLANK};
        end
        cursor_row   = ROWS - 1;
        res.scrolled = 1'b1;
        scrolls_seen++;
      end
    end
    res.cur_row = ROW_FW'(cursor_row);
    res.cur_col = COL_FW'(cursor_col);
  endtask

  always @(posedge clk) begin
    console_result_t got;
    console_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) begin
        screen[i] = '0;
      end
      cursor_row = 0;
      cursor_col = 0;
      attribute = COLOR_RESET;
      cursor_cell_q.delete();
      mismatches = 0;
      scrolls_seen = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.cursor_row, out_mon.cursor_col, out_mon.cell_data, out_mon.scrolled};
        if (cursor_cell_q.size() == 0) begin
          report_mismatch("result transfer with nothing awaited", 0, int'(got));
        end else begin
          want = cursor_cell_q.pop_front();
          if (got.cur_row !== want.cur_row) begin
            report_mismatch("cursor_row", int'(want.cur_row), int'(got.cur_row));
          end
          if (got.cur_col !== want.cur_col) begin
            report_mismatch("cursor_col", int'(want.cur_col), int'(got.cur_col));
          end
          if (got.cell_word !== want.cell_word) begin
            report_mismatch("cell_data", int'(want.cell_word), int'(got.cell_word));
          end
          if (got.scrolled !== want.scrolled) begin
            report_mismatch("scrolled", int'(want.scrolled), int'(got.scrolled));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        console_step(in_mon.action, in_mon.char_code, in_mon.read_row, in_mon.read_col, want);
        cursor_cell_q.push_back(want);
      end
      if (cfg_wr_en) begin
        attribute = cfg_wr_data;
      end
    end
    results_outstanding <= cursor_cell_q.size();
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import tcw_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [CHAR_W-1:0] cfg_wr_data;

  int mismatches;
  int results_outstanding;
  int scrolls_seen;
  int sender_idle_pct;
  int receiver_stall_pct;
  int puts_sent;
  int reads_sent;

  logic [CHAR_W-1:0] attr_by_phase [4];

  tcw_in_if  in_ch ();
  tcw_out_if out_ch ();

  text_console_writer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch.sink),
    .out_ch      (out_ch.source),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  tcw_screen_checker checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_mon              (in_ch),
    .out_mon             (out_ch),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .mismatches          (mismatches),
    .results_outstanding (results_outstanding),
    .scrolls_seen        (scrolls_seen)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("text_console_writer verification failed");
    $finish;
  end

  task automatic push_item(input logic act, input logic [CHAR_W-1:0] ch,
                           input logic [ROW_FW-1:0] rd_row,
                           input logic [COL_FW-1:0] rd_col);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.char_code <= ch;
    in_ch.read_row  <= rd_row;
    in_ch.read_col  <= rd_col;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    if (act == ACT_READ) begin
      reads_sent++;
    end else begin
      puts_sent++;
    end
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    push_item(ACT_PUT, ch, ROW_FW'($urandom), COL_FW'($urandom));
  endtask

  task automatic read_cell(input logic [ROW_FW-1:0] rd_row, input logic [COL_FW-1:0] rd_col);
    push_item(ACT_READ, CHAR_W'($urandom), rd_row, rd_col);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_attribute(input logic [CHAR_W-1:0] value);
    drain_results();
    // let a bottom-row blanking pass finish before the attribute changes
    repeat (100) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_random(input int count);
    int sent;
    int kind;
    int run_len;
    int sub;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99);
      if (kind < 2) begin
        drain_results();
      end else if (kind < 6) begin
        // newline runs drive the cursor off the bottom row
        run_len = $urandom_range(5, 30);
        run_len = (run_len > count - sent) ? count - sent : run_len;
        repeat (run_len) put_char(CH_NEWLINE);
        sent += run_len;
      end else if (kind < 9) begin
        run_len = $urandom_range(1, 90);
        run_len = (run_len > count - sent) ? count - sent : run_len;
        repeat (run_len) put_char(CH_BACKSPACE);
        sent += run_len;
      end else if (kind < 11) begin
        // long printable runs wrap at the right edge
        run_len = $urandom_range(80, 170);
        run_len = (run_len > count - sent) ? count - sent : run_len;
        repeat (run_len) put_char(CHAR_W'($urandom_range(32, 126)));
        sent += run_len;
      end else if (kind < 33) begin
        sub = $urandom_range(99);
        if (sub < 80) begin
          read_cell(ROW_FW'($urandom_range(ROWS - 1)), COL_FW'($urandom_range(COLUMNS - 1)));
        end else begin
          read_cell(ROW_FW'($urandom), COL_FW'($urandom));
        end
        sent++;
      end else begin
        sub = $urandom_range(99);
        if (sub < 10) begin
          put_char(CH_NEWLINE);
        end else if (sub < 18) begin
          put_char(CH_BACKSPACE);
        end else begin
          put_char(CHAR_W'($urandom_range(255)));
        end
        sent++;
      end
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.action       <= ACT_PUT;
    in_ch.char_code    <= '0;
    in_ch.read_row     <= '0;
    in_ch.read_col     <= '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    puts_sent          = 0;
    reads_sent         = 0;
    attr_by_phase[0]   = 8'h00;
    attr_by_phase[1]   = 8'hff;
    attr_by_phase[2]   = CHAR_W'($urandom);
    attr_by_phase[3]   = 8'h80;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed part with the reset attribute
    read_cell(ROW_FW'(0), COL_FW'(0));
    read_cell(ROW_FW'(ROWS - 1), COL_FW'(COLUMNS - 1));
    read_cell(5'd31, 7'd127);
    read_cell(ROW_FW'(ROWS), COL_FW'(0));
    read_cell(ROW_FW'(0), COL_FW'(COLUMNS));
    put_char(CH_BACKSPACE);
    put_char(8'h41);
    put_char(8'h00);
    put_char(8'hff);
    put_char(8'h80);
    put_char(8'h7f);
    put_char(CH_BACKSPACE);
    read_cell(ROW_FW'(0), COL_FW'(4));
    read_cell(ROW_FW'(0), COL_FW'(2));
    put_char(CH_BLANK);
    put_char(CH_NEWLINE);
    put_char(CH_BACKSPACE);
    read_cell(ROW_FW'(0), COL_FW'(0));
    read_cell(ROW_FW'(1), COL_FW'(0));

    for (int phase = 0; phase < 4; phase++) begin
      write_attribute(attr_by_phase[phase]);
      case (phase)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 68;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 68;
        end
        default: begin
          sender_idle_pct = 11;
          receiver_stall_pct = 11;
        end
      endcase
      run_random(210);
    end

    drain_results();
    repeat (100) @(posedge clk);
    $display("run covered %0d items: %0d puts and %0d reads, %0d screen scrolls",
             puts_sent + reads_sent, puts_sent, reads_sent, scrolls_seen);
    $display("attributes 07 %02h %02h %02h %02h under four flow-control mixes",
             attr_by_phase[0], attr_by_phase[1], attr_by_phase[2], attr_by_phase[3]);
    if (mismatches == 0) begin
      $display("text_console_writer verification clean");
    end else begin
      $display("text_console_writer verification failed");
    end
    $finish;
  end

endmodule
